### sv/fat_chain_allocator_core_macros.svh
// Assertion macros shared by the allocation table RTL
`ifndef FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH
`define FAT_CHAIN_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fca_pkg.sv
// Types, codes and widths of the allocation table block
package fca_pkg;

    localparam int FCA_TABLE_DEPTH = 1024;
    localparam int FCA_ENTRY_WIDTH = 32;

    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int LEN_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_ALLOC = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_CODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE       = 2'd2;

    localparam logic [LEN_W-1:0]   RST_ENTRIES_IN_USE = 11'd1024;
    localparam logic [VALUE_W-1:0] RST_FREE_CODE      = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] RST_END_CODE       = 32'hFFFF_FFFF;

endpackage

### sv/fca_chan_if.sv
// Request, response and register-write channels of the allocation table block
interface fca_in_if import fca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
    logic [LEN_W-1:0]     chain_length;

    modport source (output valid, func, index, value, chain_length, input ready);
    modport sink   (input valid, func, index, value, chain_length, output ready);
endinterface

interface fca_out_if import fca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   chain_head;
    logic [VALUE_W-1:0]   entry_value;
    logic [LEN_W-1:0]     free_count;

    modport source (output valid, status, chain_head, entry_value, free_count, input ready);
    modport sink   (input valid, status, chain_head, entry_value, free_count, output ready);
endinterface

interface fca_cfg_if import fca_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/fat_chain_allocator_core.sv
// Allocation table core: table memory, scan sequencer and register file
// Write and read: one registered memory read in S_ACCESS; the result is loaded from S_DONE.
// Allocate: scans up to L = min(entries_in_use, TABLE_DEPTH) entries, one memory
//   read per cycle through a single compare unit, first to count, then to link.
// One request at a time; the next is accepted once the current one has its result.
// Synchronous reset starts a clearing pass over all TABLE_DEPTH entries (1024 by default)
//   that zeroes the table; no request is taken until it ends. Config writes always.
`include "fat_chain_allocator_core_macros.svh"

module fat_chain_allocator_core import fca_pkg::*; #(
    parameter int TABLE_DEPTH = FCA_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = FCA_ENTRY_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fca_in_if.sink    i_req,
    fca_out_if.source o_rsp,
    fca_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;
    localparam int EW = ENTRY_WIDTH;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_ACCESS = 7'b0000100,
        S_COUNT  = 7'b0001000,
        S_LINK   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    // registers
    t_state              r_state, n_state;
    logic [SW-1:0]       r_ptr, n_ptr;
    logic                r_pv, n_pv;
    logic [AW-1:0]       r_pa, n_pa;
    logic [SW-1:0]       r_cnt, n_cnt;
    logic [SW-1:0]       r_linked, n_linked;
    logic                r_have_prev, n_have_prev;
    logic [AW-1:0]       r_prev, n_prev;
    logic [AW-1:0]       r_first, n_first;
    logic [STATUS_W-1:0] r_status, n_status;

    t_func               r_func;
    logic [INDEX_W-1:0]  r_idx;
    logic [EW-1:0]       r_val;
    logic [LEN_W-1:0]    r_len;
    logic [SW-1:0]       r_limit;

    logic [LEN_W-1:0]    r_eiu;
    logic [VALUE_W-1:0]  r_free_code;
    logic [VALUE_W-1:0]  r_end_code;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [INDEX_W-1:0]  r_o_first;
    logic [VALUE_W-1:0]  r_o_value;
    logic [LEN_W-1:0]    r_o_count;

    // table memory
    logic [EW-1:0]       mem [TABLE_DEPTH];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       r_rd_data;

    logic                req_acc;
    logic                out_load;
    logic [SW-1:0]       limit_now;
    logic [EW-1:0]       fcode;
    logic                scan_issue;
    logic                hit;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign fcode      = r_free_code[EW-1:0];
    assign limit_now  = (32'(r_eiu) > 32'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(r_eiu);
    assign scan_issue = (r_ptr < r_limit);
    assign hit        = r_pv && (r_rd_data == fcode);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pv        = 1'b0;
        n_cnt       = r_cnt;
        n_linked    = r_linked;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_first     = r_first;
        n_status    = r_status;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_prev;
        mem_wdata   = '0;
        mem_raddr   = AW'(r_idx);

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                if (r_ptr == SW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + SW'(1);
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_cnt    = '0;
                    n_first  = '0;
                    n_status = ST_OK;
                    n_ptr    = '0;
                    case (t_func'(i_req.func))
                        FN_WRITE, FN_READ: n_state = S_ACCESS;
                        FN_ALLOC:          n_state = S_COUNT;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            S_ACCESS: begin
                // read address is r_idx; data is ready in S_DONE
                if (32'(r_idx) >= 32'(r_limit)) begin
                    n_status = ST_RANGE;
                end else if (r_func == FN_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_idx);
                    mem_wdata = r_val;
                end
                n_state = S_DONE;
            end
            S_COUNT: begin
                mem_raddr = r_ptr[AW-1:0];
                if (scan_issue) begin
                    n_pv  = 1'b1;
                    n_ptr = r_ptr + SW'(1);
                end
                if (hit) begin
                    n_cnt = r_cnt + SW'(1);
                end
                if (!scan_issue && !r_pv) begin
                    n_ptr = '0;
                    if (32'(r_cnt) < 32'(r_len)) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end else if (r_len == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_linked    = '0;
                        n_have_prev = 1'b0;
                        n_state     = S_LINK;
                    end
                end
            end
            S_LINK: begin
                mem_raddr = r_ptr[AW-1:0];
                if ((32'(r_linked) == 32'(r_len)) || (!scan_issue && !r_pv)) begin
                    n_state = S_FINISH;
                end else begin
                    if (scan_issue) begin
                        n_pv  = 1'b1;
                        n_ptr = r_ptr + SW'(1);
                    end
                    // only earlier entries are rewritten, never one still to be read
                    if (hit) begin
                        mem_we    = r_have_prev;
                        mem_waddr = r_prev;
                        mem_wdata = EW'(r_pa);
                        if (!r_have_prev) begin
                            n_first = r_pa;
                        end
                        n_prev      = r_pa;
                        n_have_prev = 1'b1;
                        n_linked    = r_linked + SW'(1);
                    end
                end
            end
            S_FINISH: begin
                mem_we    = 1'b1;
                mem_waddr = r_prev;
                mem_wdata = r_end_code[EW-1:0];
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // address read this cycle, matched against the data next cycle
        n_pa = mem_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_cnt       <= '0;
            r_linked    <= '0;
            r_have_prev <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pv        <= n_pv;
            r_cnt       <= n_cnt;
            r_linked    <= n_linked;
            r_have_prev <= n_have_prev;
            r_status    <= n_status;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pa    <= n_pa;
        r_prev  <= n_prev;
        r_first <= n_first;
        if (req_acc) begin
            r_func  <= t_func'(i_req.func);
            r_idx   <= i_req.index;
            r_val   <= i_req.value[EW-1:0];
            r_len   <= i_req.chain_length;
            r_limit <= limit_now;
        end
        if (out_load) begin
            r_o_status <= r_status;
            r_o_first  <= INDEX_W'(r_first);
            r_o_value  <= (r_func == FN_READ && r_status == ST_OK) ?
                          VALUE_W'(r_rd_data) : '0;
            r_o_count  <= LEN_W'(r_cnt);
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu       <= RST_ENTRIES_IN_USE;
            r_free_code <= RST_FREE_CODE;
            r_end_code  <= RST_END_CODE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_ENTRIES_IN_USE: r_eiu       <= i_cfg.data[LEN_W-1:0];
                CFG_FREE_CODE:      r_free_code <= i_cfg.data;
                CFG_END_CODE:       r_end_code  <= i_cfg.data;
                default:            ;
            endcase
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.chain_head  = r_o_first;
    assign o_rsp.entry_value = r_o_value;
    assign o_rsp.free_count  = r_o_count;

    `FCA_ASSERT_IMP(a_cnt_in_limit, r_state == S_COUNT, 32'(r_cnt) <= 32'(r_limit), "free count beyond limit")
    `FCA_ASSERT_IMP(a_link_bound, r_state == S_LINK, 32'(r_linked) <= 32'(r_len), "linked more than requested")
    `FCA_ASSERT_IMP(a_finish_prev, r_state == S_FINISH, r_have_prev && (32'(r_linked) == 32'(r_len)), "chain end without full chain")
    `FCA_ASSERT_NXT(a_load_from_done, out_load, r_out_valid && (r_state == S_IDLE), "result load did not complete")

endmodule

### test/testbench.sv
// Self-checking bench for the allocation table core: directed and random requests
`timescale 1ns / 100ps

module testbench import fca_pkg::*; ();

    // slowest request is an allocate over 1024 entries
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int SCAN_LATENCY   = 2 * FCA_TABLE_DEPTH + 16;
    localparam int MAX_REPORTED   = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int NUM_PHASES     = 11;

    typedef struct packed {
        t_func              func;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   chain_length;
    } fat_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  chain_head;
        logic [VALUE_W-1:0]  entry_value;
        logic [LEN_W-1:0]    free_count;
    } fat_rsp_t;

    class chain_table_scoreboard;
        logic [VALUE_W-1:0] fat_mem [FCA_TABLE_DEPTH];
        logic [LEN_W-1:0]   in_use;
        logic [VALUE_W-1:0] free_code;
        logic [VALUE_W-1:0] end_code;
        fat_rsp_t           expected_rsp [$];
        int unsigned        err_count, rsp_count, alloc_linked, alloc_refused, range_hits;

        function new();
            foreach (fat_mem[i]) fat_mem[i] = '0;
            in_use        = RST_ENTRIES_IN_USE;
            free_code     = RST_FREE_CODE;
            end_code      = RST_END_CODE;
            err_count     = 0;
            rsp_count     = 0;
            alloc_linked  = 0;
            alloc_refused = 0;
            range_hits    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_ENTRIES_IN_USE: in_use    = data[LEN_W-1:0];
                CFG_FREE_CODE:      free_code = data;
                CFG_END_CODE:       end_code  = data;
                default: ;
            endcase
        endfunction

        function int unsigned scan_limit();
            return (in_use > FCA_TABLE_DEPTH) ? FCA_TABLE_DEPTH : int'(in_use);
        endfunction

        function int unsigned count_free();
            int unsigned n, i, lim;
            n   = 0;
            lim = scan_limit();
            for (i = 0; i < lim; i++)
                if (fat_mem[i] == free_code) n++;
            return n;
        endfunction

        function void note_request(fat_req_t rq);
            fat_rsp_t    rs;
            int unsigned lim, n, linked, prev, i;
            bit          have_prev;
            rs  = '0;
            lim = scan_limit();
            case (rq.func)
                FN_WRITE, FN_READ: begin
                    if (rq.index >= lim) begin
                        rs.status = ST_RANGE;
                        range_hits++;
                    end else if (rq.func == FN_WRITE) begin
                        fat_mem[rq.index] = rq.value;
                    end else begin
                        rs.entry_value = fat_mem[rq.index];
                    end
                end
                FN_ALLOC: begin
                    n = count_free();
                    rs.free_count = n[LEN_W-1:0];
                    if (n < rq.chain_length) begin
                        rs.status = ST_NO_SPACE;
                        alloc_refused++;
                    end else begin
                        // first-fit, ascending; chain picked from the entries free at the start
                        alloc_linked++;
                        linked    = 0;
                        prev      = 0;
                        have_prev = 1'b0;
                        for (i = 0; i < lim && linked < rq.chain_length; i++) begin
                            if (fat_mem[i] == free_code) begin
                                if (have_prev) fat_mem[prev] = i;
                                else rs.chain_head = i[INDEX_W-1:0];
                                prev      = i;
                                have_prev = 1'b1;
                                linked++;
                            end
                        end
                        if (have_prev) fat_mem[prev] = end_code;
                    end
                end
                default: ;
            endcase
            expected_rsp.push_back(rs);
        endfunction

        function void check_response(fat_rsp_t got);
            fat_rsp_t want;
            rsp_count++;
            if (expected_rsp.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTED)
                    $display("ERROR: unexpected response: status %0d first %0d value %h free %0d",
                             got.status, got.chain_head, got.entry_value, got.free_count);
                return;
            end
            want = expected_rsp.pop_front();
            if (got !== want) begin
                err_count++;
                if (err_count <= MAX_REPORTED) begin
                    $display("ERROR: response %0d: exp status %0d first %0d value %h free %0d",
                             rsp_count, want.status, want.chain_head, want.entry_value,
                             want.free_count);
                    $display("       got status %0d first %0d value %h free %0d",
                             got.status, got.chain_head, got.entry_value, got.free_count);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fca_in_if  req_if ();
    fca_out_if rsp_if ();
    fca_cfg_if cfg_if ();

    fat_chain_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    chain_table_scoreboard fat_sb;
    bit          stall_enable = 1'b1;
    bit          gap_enable   = 1'b1;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned req_sent     = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // response side back-pressure
    always @(posedge i_clk) begin
        if (!stall_enable) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            fat_sb.check_response(fat_rsp_t'({rsp_if.status, rsp_if.chain_head,
                                              rsp_if.entry_value, rsp_if.free_count}));
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, fat_sb.expected_rsp.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_request(input t_func f, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val, input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = gap_enable ? idle_len() : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.index        <= idx;
        req_if.value        <= val;
        req_if.chain_length <= len;
        do @(posedge i_clk); while (!req_if.ready);
        fat_sb.note_request(fat_req_t'({f, idx, val, len}));
        req_sent++;
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (fat_sb.expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        fat_sb.write_reg(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [LEN_W-1:0] n_entries, input logic [VALUE_W-1:0] fcode,
                             input logic [VALUE_W-1:0] ecode);
        wait_idle();
        write_reg(CFG_ENTRIES_IN_USE, CFG_DAT_W'(n_entries));
        write_reg(CFG_FREE_CODE, fcode);
        write_reg(CFG_END_CODE, ecode);
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        int unsigned        lim, nfree, pick, k;
        t_func              f;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        logic [LEN_W-1:0]   len;
        for (k = 0; k < n_items; k++) begin
            lim   = fat_sb.scan_limit();
            nfree = fat_sb.count_free();
            idx   = (lim != 0 && $urandom_range(0, 9) != 0) ?
                    INDEX_W'($urandom_range(0, lim - 1)) : INDEX_W'($urandom());
            val   = $urandom();
            len   = LEN_W'($urandom());
            pick  = $urandom_range(0, 99);
            // table nearly full: mostly release entries so allocates keep succeeding
            if (nfree < 2 && lim != 0 && $urandom_range(0, 9) < 6) begin
                f   = FN_WRITE;
                val = fat_sb.free_code;
            end else if (pick < 32) begin
                f = FN_WRITE;
                case ($urandom_range(0, 5))
                    0, 1, 2: val = fat_sb.free_code;
                    3:       val = fat_sb.end_code;
                    4:       val = $urandom_range(0, lim);
                    default: ;
                endcase
            end else if (pick < 52) begin
                f = FN_READ;
            end else if (pick < 92) begin
                f = FN_ALLOC;
                case ($urandom_range(0, 9))
                    0:       len = '0;
                    1:       len = LEN_W'(nfree + $urandom_range(1, 3));
                    2:       ;
                    3:       len = LEN_W'(nfree);
                    default: len = LEN_W'($urandom_range(1, (nfree > 4) ? 4 :
                                                         ((nfree == 0) ? 1 : nfree)));
                endcase
            end else begin
                f = FN_NOP;
            end
            send_request(f, idx, val, len);
        end
    endtask

    initial begin
        int unsigned        ph;
        logic [VALUE_W-1:0] fcode, ecode;

        fat_sb               = new();
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.func          = FN_WRITE;
        req_if.index         = '0;
        req_if.value         = '0;
        req_if.chain_length  = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_ENTRIES_IN_USE;
        cfg_if.data          = '0;
        rsp_if.ready         = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, freshly cleared table
        send_request(FN_READ,  10'd0,    32'h0,         11'd0);
        send_request(FN_READ,  10'd1023, 32'h0,         11'd0);
        send_request(FN_WRITE, 10'd1023, 32'hFFFF_FFFF, 11'd0);
        send_request(FN_WRITE, 10'd0,    32'hA5A5_A5A5, 11'd0);
        send_request(FN_READ,  10'd1023, 32'h0,         11'd0);
        send_request(FN_ALLOC, 10'd0,    32'h0,         11'd0);
        send_request(FN_ALLOC, 10'd0,    32'h0,         11'd3);
        send_request(FN_READ,  10'd1,    32'h0,         11'd0);
        send_request(FN_READ,  10'd3,    32'h0,         11'd0);
        send_request(FN_NOP,   10'h3FF,  32'hFFFF_FFFF, 11'h7FF);
        send_request(FN_ALLOC, 10'd0,    32'h0,         11'd1024);
        send_request(FN_ALLOC, 10'h3FF,  32'h0,         11'h7FF);

        // no entries in use
        configure(11'd0, RST_FREE_CODE, RST_END_CODE);
        send_request(FN_WRITE, 10'd0, 32'h1234_5678, 11'd0);
        send_request(FN_READ,  10'd0, 32'h0,         11'd0);
        send_request(FN_ALLOC, 10'd0, 32'h0,         11'd1);
        send_request(FN_ALLOC, 10'd0, 32'h0,         11'd0);

        // limit above the table depth clamps to the depth
        configure(11'd2047, RST_FREE_CODE, RST_END_CODE);
        send_request(FN_READ, 10'd1023, 32'h0, 11'd0);

        // link value and end marker both equal the free code
        configure(11'd4, 32'd1, 32'd1);
        send_request(FN_WRITE, 10'd0, 32'd1, 11'd0);
        send_request(FN_WRITE, 10'd1, 32'd1, 11'd0);
        send_request(FN_WRITE, 10'd2, 32'd1, 11'd0);
        send_request(FN_WRITE, 10'd3, 32'd1, 11'd0);
        send_request(FN_ALLOC, 10'd0, 32'd0, 11'd2);
        send_request(FN_ALLOC, 10'd0, 32'd0, 11'd0);
        send_request(FN_READ,  10'd0, 32'd0, 11'd0);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:  configure(11'd16, RST_FREE_CODE, RST_END_CODE);
                3:  configure(11'd1024, 32'h0, $urandom());
                5:  configure(11'd2047, 32'hFFFF_FFFF, 32'h0);
                7:  configure(11'd1, $urandom_range(0, 3), $urandom());
                9:  configure(11'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       fcode = '0;
                        1:       fcode = fat_sb.end_code;
                        2:       fcode = $urandom_range(0, 15);
                        default: fcode = $urandom();
                    endcase
                    case ($urandom_range(0, 3))
                        0:       ecode = fcode;
                        1:       ecode = '1;
                        2:       ecode = $urandom_range(0, 15);
                        default: ecode = $urandom();
                    endcase
                    configure(LEN_W'($urandom_range(2, 64)), fcode, ecode);
                end
            endcase
            // every fourth phase runs with no gaps and no back-pressure
            gap_enable   = (ph % 4 != 2);
            stall_enable = (ph % 4 != 2);
            run_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (SCAN_LATENCY) @(posedge i_clk);
        $display("summary: %0d requests, %0d responses, %0d chains linked, %0d refused, %0d range",
                 req_sent, fat_sb.rsp_count, fat_sb.alloc_linked, fat_sb.alloc_refused,
                 fat_sb.range_hits);
        $display("summary: in-use limits 0 to 2047, codes at both extremes, %0d mismatches",
                 fat_sb.err_count);
        if (fat_sb.err_count == 0 && fat_sb.expected_rsp.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
